@@ src/lmc_pkg.sv @@
// Shared types and constants for the LRU metadata cache.
// No dependencies.
package lmc_pkg;

  localparam int ENTRIES    = 11;
  localparam int META_WORDS = 33;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PTR_W      = $clog2(ENTRIES + 1);
  localparam int WIDX_W     = 6;
  localparam int RAM_DEPTH  = ENTRIES * META_WORDS;
  localparam int RAM_AW     = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_FILL   = 2'd1,
    FUNC_INVAL  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_STREAM,
    ST_ACK
  } state_e;

  typedef struct packed {
    func_e              func;
    logic [31:0]        page_address;
    logic [15:0]        page_ofs;
    logic [31:0]        address_mask;
    logic [WIDX_W-1:0]  word_index;
    logic [31:0]        data_word;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic [WIDX_W-1:0]  word_out_index;
    logic [31:0]        word_out;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic               touch_hit;
    logic               fill_tag;
    logic               inval;
    logic               scan_start;
    logic [31:0]        page_address;
    logic [15:0]        page_ofs;
    logic [31:0]        address_mask;
  } tag_cmd_t;

  typedef struct packed {
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic               scan_done;
    logic [IDX_W-1:0]   victim;
  } tag_stat_t;

endpackage

@@ src/lmc_word_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module lmc_word_ram #(
  parameter int DEPTH = 363,
  parameter int WIDTH = 32,
  parameter int AW    = 9
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/lmc_tag_store.sv @@
// Tag, valid and stamp registers: key match, masked invalidate, stamp
// update and the one-entry-a-cycle victim scan. Depends on lmc_pkg.
module lmc_tag_store (
  input  logic              clk,
  input  logic              rst,
  input  lmc_pkg::tag_cmd_t cmd,
  output lmc_pkg::tag_stat_t stat
);

  logic [lmc_pkg::ENTRIES-1:0] valid;
  logic [31:0]                 page   [lmc_pkg::ENTRIES];
  logic [15:0]                 offset [lmc_pkg::ENTRIES];
  logic [31:0]                 stamp  [lmc_pkg::ENTRIES];
  logic [31:0]                 use_counter;
  logic [lmc_pkg::PTR_W-1:0]   scan_ptr;
  logic [lmc_pkg::IDX_W-1:0]   best_idx;
  logic [31:0]                 best_stamp;

  logic [lmc_pkg::ENTRIES-1:0] match;
  logic [lmc_pkg::ENTRIES-1:0] inval_hit;
  logic [lmc_pkg::IDX_W-1:0]   hit_idx;
  logic                        touch;
  logic [lmc_pkg::IDX_W-1:0]   touch_idx;
  logic [31:0]                 cnt_inc;
  logic                        wrap;
  logic                        scan_done;
  logic [31:0]                 scan_stamp;

  always_comb begin
    hit_idx = '0;
    for (int e = lmc_pkg::ENTRIES - 1; e >= 0; e--) begin
      match[e]     = valid[e] && (page[e] == cmd.page_address)
                     && (offset[e] == cmd.page_ofs);
      inval_hit[e] = ((page[e] ^ cmd.page_address) & ~cmd.address_mask) == 32'd0;
      if (match[e]) begin
        hit_idx = lmc_pkg::IDX_W'(e);
      end
    end
  end

  assign scan_done  = (scan_ptr == lmc_pkg::PTR_W'(lmc_pkg::ENTRIES));
  assign scan_stamp = stamp[scan_ptr[lmc_pkg::IDX_W-1:0]];
  assign touch      = cmd.touch_hit || cmd.fill_tag;
  assign touch_idx  = cmd.fill_tag ? best_idx : hit_idx;
  assign cnt_inc    = use_counter + 32'd1;
  assign wrap       = (cnt_inc == '1);

  assign stat.hit       = |match;
  assign stat.hit_idx   = hit_idx;
  assign stat.scan_done = scan_done;
  assign stat.victim    = best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid       <= '0;
      use_counter <= '0;
      scan_ptr    <= lmc_pkg::PTR_W'(lmc_pkg::ENTRIES);
      best_idx    <= '0;
      for (int e = 0; e < lmc_pkg::ENTRIES; e++) begin
        stamp[e] <= '0;
      end
    end else begin
      if (cmd.inval) begin
        for (int e = 0; e < lmc_pkg::ENTRIES; e++) begin
          if (inval_hit[e]) begin
            valid[e] <= 1'b0;
          end
        end
      end
      if (cmd.fill_tag) begin
        valid[best_idx]  <= 1'b1;
        page[best_idx]   <= cmd.page_address;
        offset[best_idx] <= cmd.page_ofs;
      end
      if (touch) begin
        if (wrap) begin
          // counter hit the top: every stamp restarts from zero
          use_counter <= '0;
          for (int e = 0; e < lmc_pkg::ENTRIES; e++) begin
            stamp[e] <= '0;
          end
        end else begin
          use_counter      <= cnt_inc;
          stamp[touch_idx] <= cnt_inc;
        end
      end
      if (cmd.scan_start) begin
        best_idx   <= '0;
        best_stamp <= stamp[0];
        scan_ptr   <= lmc_pkg::PTR_W'(1);
      end else if (!scan_done) begin
        if (scan_stamp < best_stamp) begin
          best_idx   <= scan_ptr[lmc_pkg::IDX_W-1:0];
          best_stamp <= scan_stamp;
        end
        scan_ptr <= scan_ptr + lmc_pkg::PTR_W'(1);
      end
    end
  end

endmodule

@@ src/lru_metadata_cache_core.sv @@
// Top level of the LRU metadata cache: control sequencer, word RAM and a
// two-word result queue. Depends on lmc_pkg, lmc_tag_store, lmc_word_ram.
//
// Fully associative cache of 11 entries, each with 33 metadata words held in
// one synchronous RAM. A word is registered when taken and decoded in the next
// cycle, against all tags at once. A lookup hit then streams its 33 words at
// one per cycle from the RAM read port while the result queue has room; a miss,
// an invalidate, a later fill word or an unused code answers with one word.
// The next item is taken only after the last read is issued or the answer is
// queued. Fill word 0 walks the stamps one entry a cycle to find the victim.
// Results queue two deep, so a new word is taken while results wait.
// No clearing pass after reset: the word RAM needs none.
module lru_metadata_cache_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  lmc_pkg::in_word_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output lmc_pkg::out_word_t rsp
);

  lmc_pkg::state_e   state, state_next;
  lmc_pkg::in_word_t reqr;
  lmc_pkg::tag_cmd_t cmd;
  lmc_pkg::tag_stat_t stat;

  logic [lmc_pkg::IDX_W-1:0]  fill_slot;
  logic [lmc_pkg::RAM_AW-1:0] base_addr, base_next;
  logic [lmc_pkg::WIDX_W-1:0] rd_word;
  logic                       pend;
  logic [lmc_pkg::WIDX_W-1:0] pend_idx;
  logic                       pend_last;

  logic                       ram_we, ram_re;
  logic [lmc_pkg::RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]                ram_wdata, ram_rdata;

  lmc_pkg::out_word_t fifo [2];
  logic [1:0]         fcnt;
  logic               frd, fwr;
  logic               push, pop, ack_push;
  lmc_pkg::out_word_t push_data;
  logic [2:0]         used;
  logic               credit_ok;
  logic               last_issue;

  function automatic logic [lmc_pkg::RAM_AW-1:0] word_addr(
    input logic [lmc_pkg::IDX_W-1:0]  slot,
    input logic [lmc_pkg::WIDX_W-1:0] widx
  );
    return lmc_pkg::RAM_AW'(slot) * lmc_pkg::RAM_AW'(lmc_pkg::META_WORDS)
           + lmc_pkg::RAM_AW'(widx);
  endfunction

  lmc_tag_store u_tags (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  lmc_word_ram #(
    .DEPTH (lmc_pkg::RAM_DEPTH),
    .WIDTH (32),
    .AW    (lmc_pkg::RAM_AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // result queue
  assign rsp_valid = (fcnt != 2'd0);
  assign rsp       = fifo[frd];
  assign pop       = rsp_valid && rsp_ready;
  assign used      = 3'(fcnt) + 3'(pend) - 3'(pop);
  assign credit_ok = (used < 3'd2);
  assign push      = pend || ack_push;
  assign last_issue = (rd_word == lmc_pkg::WIDX_W'(lmc_pkg::META_WORDS - 1));

  always_comb begin
    if (pend) begin
      push_data = '{hit: 1'b1, word_out_index: pend_idx, word_out: ram_rdata,
                    last: pend_last};
    end else begin
      push_data = '{hit: 1'b0, word_out_index: '0, word_out: '0, last: 1'b1};
    end
  end

  assign req_ready = (state == lmc_pkg::ST_IDLE);

  always_comb begin
    state_next       = state;
    cmd              = '0;
    cmd.page_address = reqr.page_address;
    cmd.page_ofs     = reqr.page_ofs;
    cmd.address_mask = reqr.address_mask;
    ram_we           = 1'b0;
    ram_waddr        = word_addr(fill_slot, reqr.word_index);
    ram_wdata        = reqr.data_word;
    ram_re           = 1'b0;
    ram_raddr        = base_addr + lmc_pkg::RAM_AW'(rd_word);
    ack_push         = 1'b0;
    base_next        = word_addr(stat.hit_idx, '0);
    unique case (state)
      lmc_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = lmc_pkg::ST_DECODE;
        end
      end
      lmc_pkg::ST_DECODE: begin
        unique case (reqr.func)
          lmc_pkg::FUNC_LOOKUP: begin
            cmd.touch_hit = stat.hit;
            state_next    = stat.hit ? lmc_pkg::ST_STREAM : lmc_pkg::ST_ACK;
          end
          lmc_pkg::FUNC_FILL: begin
            if (reqr.word_index == '0) begin
              cmd.scan_start = 1'b1;
              state_next     = lmc_pkg::ST_SCAN;
            end else begin
              ram_we     = (reqr.word_index < lmc_pkg::WIDX_W'(lmc_pkg::META_WORDS));
              state_next = lmc_pkg::ST_ACK;
            end
          end
          lmc_pkg::FUNC_INVAL: begin
            cmd.inval  = 1'b1;
            state_next = lmc_pkg::ST_ACK;
          end
          lmc_pkg::FUNC_NOP: begin
            state_next = lmc_pkg::ST_ACK;
          end
        endcase
      end
      lmc_pkg::ST_SCAN: begin
        if (stat.scan_done) begin
          cmd.fill_tag = 1'b1;
          ram_we       = 1'b1;
          ram_waddr    = word_addr(stat.victim, '0);
          state_next   = lmc_pkg::ST_ACK;
        end
      end
      lmc_pkg::ST_STREAM: begin
        if (credit_ok) begin
          ram_re = 1'b1;
          if (last_issue) begin
            state_next = lmc_pkg::ST_IDLE;
          end
        end
      end
      lmc_pkg::ST_ACK: begin
        if (credit_ok && !pend) begin
          ack_push   = 1'b1;
          state_next = lmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lmc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lmc_pkg::ST_IDLE;
      fill_slot <= '0;
      pend      <= 1'b0;
      fcnt      <= '0;
      frd       <= 1'b0;
      fwr       <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= ram_re;
      if (state == lmc_pkg::ST_SCAN && stat.scan_done) begin
        fill_slot <= stat.victim;
      end
      if (push) begin
        fwr <= ~fwr;
      end
      if (pop) begin
        frd <= ~frd;
      end
      fcnt <= fcnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      reqr <= req;
    end
    if (state == lmc_pkg::ST_DECODE) begin
      base_addr <= base_next;
      rd_word   <= '0;
    end else if (ram_re) begin
      rd_word <= rd_word + lmc_pkg::WIDX_W'(1);
    end
    pend_idx  <= rd_word;
    pend_last <= last_issue;
    if (push) begin
      fifo[fwr] <= push_data;
    end
  end

endmodule
